@@ src/sat_pkg.sv @@
`timescale 1ns / 1ps
package sat_pkg;

  localparam int unsigned POINTS_PER_SET_DEF = 5;
  localparam int unsigned COORD_BITS_DEF     = 24;
  localparam int unsigned SLOT_W             = 3;

  // axis codes, in test order
  localparam logic [2:0] AXIS_X     = 3'd0;
  localparam logic [2:0] AXIS_Y     = 3'd1;
  localparam logic [2:0] AXIS_Z     = 3'd2;
  localparam logic [2:0] AXIS_E0    = 3'd3;
  localparam logic [2:0] AXIS_E1    = 3'd4;
  localparam logic [2:0] AXIS_CROSS = 3'd5;

  // how one multiply step contributes to a projection
  typedef enum logic [1:0] {
    KIND_SINGLE = 2'd0,
    KIND_LO     = 2'd1,
    KIND_HI     = 2'd2
  } kind_e;

  typedef struct packed {
    logic  valid;
    logic  set;
    logic  first;
    kind_e kind;
  } sat_tag_t;

endpackage

@@ src/sat_if.sv @@
`timescale 1ns / 1ps
interface sat_in_if import sat_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         set_select;
  logic [SLOT_W-1:0]            point_slot;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;
  logic signed [COORD_BITS-1:0] coord_z;
  logic                         run_test;

  modport source (output valid, set_select, point_slot, coord_x, coord_y, coord_z, run_test,
                  input ready);
  modport sink (input valid, set_select, point_slot, coord_x, coord_y, coord_z, run_test,
                output ready);
endinterface

interface sat_out_if;
  logic valid;
  logic ready;
  logic overlap;

  modport source (output valid, overlap, input ready);
  modport sink (input valid, overlap, output ready);
endinterface

@@ src/separating_axis_rect_overlap_top.sv @@
`timescale 1ns / 1ps
// Point beats without run_test are taken one per cycle while no test is running.
// A run_test beat starts a test that ends early when an axis separates; three shared
// multiplier lanes and one RAM read per step carry it: one step per point and axis, two on
// the cross-product axis.
// Reset clears control only; point memory is undefined until written.
module separating_axis_rect_overlap_top import sat_pkg::*; #(
  parameter int unsigned POINTS_PER_SET = POINTS_PER_SET_DEF,
  parameter int unsigned COORD_BITS     = COORD_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sat_in_if.sink    in_i,
  sat_out_if.source out_o
);
  localparam int unsigned C   = COORD_BITS;
  localparam int unsigned EW  = C + 1;
  localparam int unsigned AW  = 2 * C + 3;
  localparam int unsigned H   = C + 2;
  localparam int unsigned BW  = C + 3;
  localparam int unsigned PRW = EW + BW;
  localparam int unsigned PW  = 3 * C + 5;
  localparam int unsigned NE  = 2 * POINTS_PER_SET;
  localparam int unsigned IW  = $clog2(NE);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EDGE  = 7'b0000010,
    S_CROSS = 7'b0000100,
    S_AXIS  = 7'b0001000,
    S_DRAIN = 7'b0010000,
    S_CHECK = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e         state_q, state_d;
  logic [1:0]     cnt_q, cnt_d;
  logic [2:0]     axis_q, axis_d;
  logic [IW-1:0]  pt_q, pt_d;
  logic           hi_q, hi_d;
  logic           out_valid_q, out_valid_d;
  logic           overlap_q, overlap_d;
  logic           res_q, res_d;
  sat_tag_t       tag0, tag1_q, tag2_q;

  logic signed [EW-1:0] pa_q [3];
  logic signed [EW-1:0] e0_q [3];
  logic signed [EW-1:0] e1_q [3];
  logic signed [AW-1:0] cross_q [3];
  logic signed [EW-1:0] rd_c [3];
  logic signed [AW-1:0] comp [3];
  logic signed [EW-1:0] mul_a [3];
  logic signed [BW-1:0] mul_b [3];
  logic signed [PRW-1:0] prod [3];

  logic           accept, we, sep;
  logic [IW-1:0]  waddr, raddr;
  logic [3*C-1:0] wdata, rdata;

  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign we = accept && ({1'b0, in_i.point_slot} < 4'(POINTS_PER_SET));
  assign waddr = IW'(in_i.point_slot) + (in_i.set_select ? IW'(POINTS_PER_SET) : '0);
  assign wdata = {in_i.coord_z, in_i.coord_y, in_i.coord_x};

  always_comb begin
    raddr = '0;
    if (state_q == S_EDGE) begin
      raddr = IW'(POINTS_PER_SET) + IW'(cnt_q);
    end else if (state_q == S_AXIS) begin
      raddr = pt_q;
    end
  end

  sat_ram #(.WIDTH(3 * C), .DEPTH(NE)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rd_c[k] = EW'($signed(rdata[k*C +: C]));
    end
  end

  // axis components for the current pass
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      case (axis_q)
        AXIS_X, AXIS_Y, AXIS_Z: comp[k] = (axis_q == 3'(k)) ? AW'(1) : '0;
        AXIS_E0:                comp[k] = AW'(e0_q[k]);
        AXIS_E1:                comp[k] = AW'(e1_q[k]);
        AXIS_CROSS:             comp[k] = cross_q[k];
        default:                comp[k] = '0;
      endcase
    end
  end

  // lane operands: edge products while forming the cross axis, else point times axis chunk
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      int n1, n2;
      n1 = (k == 2) ? 0 : k + 1;
      n2 = (k == 0) ? 2 : k - 1;
      if (state_q == S_CROSS) begin
        mul_a[k] = (cnt_q == 2'd0) ? e0_q[n1] : e0_q[n2];
        mul_b[k] = (cnt_q == 2'd0) ? BW'(e1_q[n2]) : BW'(e1_q[n1]);
      end else begin
        mul_a[k] = rd_c[k];
        case (tag1_q.kind)
          KIND_SINGLE: mul_b[k] = comp[k][BW-1:0];
          KIND_LO:     mul_b[k] = {1'b0, comp[k][H-1:0]};
          KIND_HI:     mul_b[k] = BW'($signed(comp[k][AW-1:H]));
          default:     mul_b[k] = '0;
        endcase
      end
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    sat_mul #(.A_W(EW), .B_W(BW)) u_mul (
      .clk_i (clk_i),
      .a_i   (mul_a[g]),
      .b_i   (mul_b[g]),
      .p_o   (prod[g])
    );
  end

  sat_proj #(.PRW(PRW), .PW(PW), .H(H)) u_proj (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (tag2_q),
    .prod_i (prod),
    .sep_o  (sep)
  );

  always_comb begin
    tag0       = '0;
    tag0.valid = (state_q == S_AXIS);
    tag0.set   = (pt_q >= IW'(POINTS_PER_SET));
    tag0.first = (pt_q == '0) || (pt_q == IW'(POINTS_PER_SET));
    if (axis_q == AXIS_CROSS) begin
      tag0.kind = hi_q ? KIND_HI : KIND_LO;
    end else begin
      tag0.kind = KIND_SINGLE;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    axis_d      = axis_q;
    pt_d        = pt_q;
    hi_d        = hi_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_o.ready;
    overlap_d   = overlap_q;
    case (state_q)
      S_IDLE: begin
        if (accept && in_i.run_test) begin
          state_d = S_EDGE;
          cnt_d   = '0;
        end
      end
      S_EDGE: begin
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          state_d = S_CROSS;
          cnt_d   = '0;
        end
      end
      S_CROSS: begin
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd2) begin
          state_d = S_AXIS;
          axis_d  = AXIS_X;
          pt_d    = '0;
          hi_d    = 1'b0;
        end
      end
      S_AXIS: begin
        hi_d = (axis_q == AXIS_CROSS) && !hi_q;
        if (!hi_d) begin
          if (pt_q == IW'(NE - 1)) begin
            state_d = S_DRAIN;
            cnt_d   = '0;
          end else begin
            pt_d = pt_q + IW'(1);
          end
        end
      end
      S_DRAIN: begin
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd2) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sep) begin
          res_d   = 1'b0;
          state_d = S_DONE;
        end else if (axis_q == AXIS_CROSS) begin
          res_d   = 1'b1;
          state_d = S_DONE;
        end else begin
          axis_d  = axis_q + 3'd1;
          pt_d    = '0;
          hi_d    = 1'b0;
          state_d = S_AXIS;
        end
      end
      S_DONE: begin
        // hold until the previous result beat is gone
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          overlap_d   = res_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      axis_q      <= AXIS_X;
      pt_q        <= '0;
      hi_q        <= 1'b0;
      out_valid_q <= 1'b0;
      tag1_q      <= '0;
      tag2_q      <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      axis_q      <= axis_d;
      pt_q        <= pt_d;
      hi_q        <= hi_d;
      out_valid_q <= out_valid_d;
      tag1_q      <= tag0;
      tag2_q      <= tag1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q     <= res_d;
    overlap_q <= overlap_d;
    for (int k = 0; k < 3; k++) begin
      if (state_q == S_EDGE) begin
        if (cnt_q == 2'd1) begin
          pa_q[k] <= rd_c[k];
        end else if (cnt_q == 2'd2) begin
          e0_q[k] <= rd_c[k] - pa_q[k];
          pa_q[k] <= rd_c[k];
        end else if (cnt_q == 2'd3) begin
          e1_q[k] <= rd_c[k] - pa_q[k];
        end
      end
      if (state_q == S_CROSS) begin
        if (cnt_q == 2'd1) begin
          cross_q[k] <= AW'(prod[k]);
        end else if (cnt_q == 2'd2) begin
          cross_q[k] <= cross_q[k] - AW'(prod[k]);
        end
      end
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.overlap = overlap_q;

`ifndef ASSERT_OFF
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state register not one-hot");

  a_run_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.run_test) |=> (state_q == S_EDGE))
    else $error("test did not start after run beat");

  a_point_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !in_i.run_test) |=> (state_q == S_IDLE))
    else $error("plain point beat left idle");

  a_tag_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag2_q.valid |-> (state_q == S_AXIS || state_q == S_DRAIN))
    else $error("projection step outside an axis pass");
`endif
endmodule

@@ src/sat_ram.sv @@
`timescale 1ns / 1ps
module sat_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

@@ src/sat_mul.sv @@
`timescale 1ns / 1ps
module sat_mul #(
  parameter int unsigned A_W = 25,
  parameter int unsigned B_W = 27
) (
  input  logic                      clk_i,
  input  logic signed [A_W-1:0]     a_i,
  input  logic signed [B_W-1:0]     b_i,
  output logic signed [A_W+B_W-1:0] p_o
);
  always_ff @(posedge clk_i) begin
    p_o <= (A_W+B_W)'(a_i) * (A_W+B_W)'(b_i);
  end
endmodule

@@ src/sat_proj.sv @@
`timescale 1ns / 1ps
module sat_proj import sat_pkg::*; #(
  parameter int unsigned PRW = 52,
  parameter int unsigned PW  = 77,
  parameter int unsigned H   = 26
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sat_tag_t              tag_i,
  input  logic signed [PRW-1:0] prod_i [3],
  output logic                  sep_o
);
  logic signed [PW-1:0] sum_w, hi_w;
  logic signed [PW-1:0] lo_acc_q, proj_q;
  logic signed [PW-1:0] own_lo_q, own_hi_q, oth_lo_q, oth_hi_q;
  logic                 vld3_q, set3_q, first3_q;

  assign sum_w = PW'(prod_i[0]) + PW'(prod_i[1]) + PW'(prod_i[2]);
  assign hi_w  = (sum_w <<< H) + lo_acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld3_q <= 1'b0;
    end else begin
      vld3_q <= tag_i.valid && (tag_i.kind != KIND_LO);
    end
  end

  always_ff @(posedge clk_i) begin
    set3_q   <= tag_i.set;
    first3_q <= tag_i.first;
    if (tag_i.valid && tag_i.kind == KIND_LO) begin
      lo_acc_q <= sum_w;
    end
    proj_q <= (tag_i.kind == KIND_HI) ? hi_w : sum_w;

    // fold the projection into its set's interval
    if (vld3_q) begin
      if (!set3_q) begin
        if (first3_q || proj_q < own_lo_q) own_lo_q <= proj_q;
        if (first3_q || proj_q > own_hi_q) own_hi_q <= proj_q;
      end else begin
        if (first3_q || proj_q < oth_lo_q) oth_lo_q <= proj_q;
        if (first3_q || proj_q > oth_hi_q) oth_hi_q <= proj_q;
      end
    end
  end

  assign sep_o = (own_hi_q < oth_lo_q) || (oth_hi_q < own_lo_q);
endmodule

@@ verif/tb_separating_axis_rect_overlap_top.sv @@
`timescale 1ns / 1ps
module tb_separating_axis_rect_overlap_top;
  import sat_pkg::*;

  localparam int unsigned NPTS = POINTS_PER_SET_DEF;
  localparam int unsigned CW   = COORD_BITS_DEF;
  localparam int unsigned NUM_RAND = 1450;
  localparam int unsigned LATENCY = 14 * NPTS + 32;
  localparam longint LIMIT = 2000000;

  typedef logic signed [127:0] wide_t;
  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    logic       set_select;
    logic [2:0] point_slot;
    coord_t     coord_x;
    coord_t     coord_y;
    coord_t     coord_z;
    logic       run_test;
  } point_beat_t;

  class overlap_board;
    coord_t px[2*NPTS];
    coord_t py[2*NPTS];
    coord_t pz[2*NPTS];
    bit     pending[$];
    int     errors;

    function wide_t project(int idx, wide_t ax, wide_t ay, wide_t az);
      wide_t s;
      s = wide_t'(px[idx]) * ax + wide_t'(py[idx]) * ay + wide_t'(pz[idx]) * az;
      return s;
    endfunction

    function bit sets_overlap();
      wide_t ax[6], ay[6], az[6];
      wide_t e0x, e0y, e0z, e1x, e1y, e1z;
      wide_t p, lo0, hi0, lo1, hi1;
      int b;
      b = NPTS;
      e0x = wide_t'(px[b+1]) - wide_t'(px[b]);
      e0y = wide_t'(py[b+1]) - wide_t'(py[b]);
      e0z = wide_t'(pz[b+1]) - wide_t'(pz[b]);
      e1x = wide_t'(px[b+2]) - wide_t'(px[b+1]);
      e1y = wide_t'(py[b+2]) - wide_t'(py[b+1]);
      e1z = wide_t'(pz[b+2]) - wide_t'(pz[b+1]);
      ax[0] = wide_t'(1); ay[0] = '0; az[0] = '0;
      ax[1] = '0; ay[1] = wide_t'(1); az[1] = '0;
      ax[2] = '0; ay[2] = '0; az[2] = wide_t'(1);
      ax[3] = e0x; ay[3] = e0y; az[3] = e0z;
      ax[4] = e1x; ay[4] = e1y; az[4] = e1z;
      ax[5] = e0y * e1z - e0z * e1y;
      ay[5] = e0z * e1x - e0x * e1z;
      az[5] = e0x * e1y - e0y * e1x;
      for (int a = 0; a < 6; a++) begin
        for (int i = 0; i < NPTS; i++) begin
          p = project(i, ax[a], ay[a], az[a]);
          if (i == 0 || p < lo0) lo0 = p;
          if (i == 0 || p > hi0) hi0 = p;
          p = project(b + i, ax[a], ay[a], az[a]);
          if (i == 0 || p < lo1) lo1 = p;
          if (i == 0 || p > hi1) hi1 = p;
        end
        if (hi0 < lo1 || hi1 < lo0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_point(point_beat_t t);
      int idx;
      if (t.point_slot < NPTS) begin
        idx = t.set_select * NPTS + t.point_slot;
        px[idx] = t.coord_x;
        py[idx] = t.coord_y;
        pz[idx] = t.coord_z;
      end
      if (t.run_test) pending = {pending, sets_overlap()};
    endfunction

    function void check_result(logic got);
      bit exp_v;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual overlap=%0b", $time, got);
        errors++;
        return;
      end
      exp_v = pending.pop_front();
      if (got !== exp_v) begin
        $display("%0t: overlap mismatch: expected %0b, actual %0b", $time, exp_v, got);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  sat_in_if  in_bus ();
  sat_out_if out_bus ();

  separating_axis_rect_overlap_top uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus.sink),
    .out_o (out_bus.source)
  );

  overlap_board board = new();
  longint cycle_cnt = 0;
  int burst_left = 0;
  int stall_mode = 0;

  initial begin
    in_bus.valid      = 1'b0;
    in_bus.set_select = 1'b0;
    in_bus.point_slot = '0;
    in_bus.coord_x    = '0;
    in_bus.coord_y    = '0;
    in_bus.coord_z    = '0;
    in_bus.run_test   = 1'b0;
    out_bus.ready     = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: switch stall pattern now and then
  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_bus.ready <= 1'b1;
      1: out_bus.ready <= ($urandom_range(0, 3) != 0);
      2: out_bus.ready <= ($urandom_range(0, 1) != 0);
      default: out_bus.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) board.check_result(out_bus.overlap);
  end

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(0, 2000)) - 1000);
      2: return {1'b1, {(CW-1){1'b0}}};
      3: return {1'b0, {(CW-1){1'b1}}};
      default: return coord_t'($signed($urandom_range(0, 200000)) - 100000);
    endcase
  endfunction

  task automatic send_point(point_beat_t t);
    if (burst_left == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 40);
    end
    in_bus.valid      <= 1'b1;
    in_bus.set_select <= t.set_select;
    in_bus.point_slot <= t.point_slot;
    in_bus.coord_x    <= t.coord_x;
    in_bus.coord_y    <= t.coord_y;
    in_bus.coord_z    <= t.coord_z;
    in_bus.run_test   <= t.run_test;
    do @(posedge clk_i); while (!in_bus.ready);
    board.note_point(t);
    burst_left--;
  endtask

  task automatic send_xyz(bit s, int slot, coord_t x, coord_t y, coord_t z, bit run);
    point_beat_t t;
    t.set_select = s;
    t.point_slot = slot[2:0];
    t.coord_x = x;
    t.coord_y = y;
    t.coord_z = z;
    t.run_test = run;
    send_point(t);
  endtask

  // write all ten points in random order, coords per mode; run on last
  task automatic send_rects(int mode, bit noise);
    int order[2*NPTS];
    int j, k;
    for (int i = 0; i < 2*NPTS; i++) order[i] = i;
    for (int i = 2*NPTS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      k = order[i]; order[i] = order[j]; order[j] = k;
    end
    for (int i = 0; i < 2*NPTS; i++) begin
      if (noise && $urandom_range(0, 4) == 0)
        send_xyz(1'($urandom_range(0, 1)), int'($urandom_range(NPTS, 7)),
                 rand_coord(0), rand_coord(0), rand_coord(0), 1'($urandom_range(0, 1)));
      send_xyz(1'(order[i] / NPTS), int'(order[i] % NPTS), rand_coord(mode),
               rand_coord(mode), rand_coord(mode), i == 2*NPTS - 1);
    end
  endtask

  initial begin
    int sent;
    coord_t mn, mx;
    mn = {1'b1, {(CW-1){1'b0}}};
    mx = {1'b0, {(CW-1){1'b1}}};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: identical points, extremes, separated boxes, degenerate axes
    for (int i = 0; i < 2*NPTS; i++)
      send_xyz(1'(i / NPTS), int'(i % NPTS), '0, '0, '0, i == 2*NPTS - 1);
    for (int i = 0; i < 2*NPTS; i++)
      send_xyz(1'(i / NPTS), int'(i % NPTS), (i / NPTS) ? mx : mn, (i % 2) ? mx : mn,
               (i % 3) ? mn : mx, 1'b0);
    send_xyz(1'b0, 7, mx, mn, mx, 1'b1);
    send_xyz(1'b1, 5, mn, mx, mn, 1'b1);
    send_xyz(1'b0, 0, coord_t'(100), '0, '0, 1'b1);
    send_xyz(1'b1, 4, coord_t'(-1), coord_t'(-1), coord_t'(-1), 1'b1);
    sent = 0;
    while (sent < NUM_RAND) begin
      send_rects($urandom_range(0, 4), $urandom_range(0, 3) == 0);
      sent += 2*NPTS;
      // partial rewrites keep the stores full while mixing sequences
      repeat ($urandom_range(0, 3)) begin
        send_xyz(1'($urandom_range(0, 1)), int'($urandom_range(0, 7)), rand_coord(4),
                 rand_coord(1), rand_coord(0), 1'($urandom_range(0, 1)));
        sent++;
      end
    end
    in_bus.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 20) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
